/* hw/rtl/rfb_pkg.sv */
package rfb_pkg;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] TERM_BYTE  = 8'h0D;

   localparam int CSR_COUNT   = 3;
   localparam int CSR_INDEX_W = $clog2(CSR_COUNT + 1);
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_HIGH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_LOW  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL   = CSR_INDEX_W'(2);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] addr_high;
      logic [7:0] addr_low;
      logic [7:0] channel;
   } cfg_type;

   // one classified request on its way to the back end
   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] data;
      logic [7:0] sum;
   } cmd_type;

endpackage

/* hw/rtl/rfb_front.sv */
module rfb_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   input  rfb_pkg::req_type req_data,
   input  logic            queue_full,
   output logic            cmd_push,
   output rfb_pkg::cmd_type cmd_data
);

   logic       inside_ff, inside_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] sum_base;

   assign cmd_push = req_push && !queue_full;
   assign sum_base = inside_ff ? sum_ff : rfb_pkg::START_BYTE;

   always_comb begin
      cmd_data.first = !inside_ff;
      cmd_data.last  = req_data.is_last;
      cmd_data.data  = req_data.payload_byte;
      cmd_data.sum   = sum_base + req_data.payload_byte;
      inside_in      = inside_ff;
      sum_in         = sum_ff;
      if (cmd_push) begin
         inside_in = !req_data.is_last;
         sum_in    = req_data.is_last ? 8'h00 : cmd_data.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         sum_ff    <= 8'h00;
      end else begin
         inside_ff <= inside_in;
         sum_ff    <= sum_in;
      end
   end

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      cmd_push && req_data.is_last |=> !inside_ff && sum_ff == 8'h00)
      else $error("frame not closed after last byte");
   a_first_sum: assert property (@(posedge clock) disable iff (reset)
      cmd_push && !inside_ff |-> cmd_data.sum == rfb_pkg::START_BYTE + req_data.payload_byte)
      else $error("checksum not seeded with start byte");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !cmd_push)
      else $error("push into full queue");

endmodule

/* hw/rtl/rfb_cmd_queue.sv */
module rfb_cmd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rfb_pkg::cmd_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output rfb_pkg::cmd_type head
);

   rfb_pkg::cmd_type mem_ff [rfb_pkg::QUEUE_DEPTH];

   logic [rfb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rfb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rfb_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_pop;

   assign full   = count_ff == rfb_pkg::QUEUE_CNT_W'(rfb_pkg::QUEUE_DEPTH);
   assign valid  = count_ff != '0;
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rfb_pkg::QUEUE_CNT_W'(rfb_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      rfb_pkg::QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff) == rfb_pkg::QUEUE_PTR_W'(count_ff))
      else $error("queue pointers disagree with count");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("pop from empty queue");

endmodule

/* hw/rtl/rfb_back.sv */
module rfb_back (
   input  logic            clock,
   input  logic            reset,
   input  rfb_pkg::cfg_type cfg,
   input  logic            q_valid,
   input  rfb_pkg::cmd_type q_head,
   output logic            q_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rfb_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      PH_ADDR_HIGH,
      PH_ADDR_LOW,
      PH_CHANNEL,
      PH_START,
      PH_DATA,
      PH_SUM,
      PH_TERM
   } phase_type;

   phase_type        phase_ff, phase_in, cur_phase, next_phase;
   logic             busy_ff, busy_in;
   logic             out_valid_ff, out_valid_in;
   rfb_pkg::rsp_type out_ff, out_in;
   rfb_pkg::rsp_type emit;
   logic             out_free, fire, done;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign fire      = q_valid && out_free;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      if (busy_ff) begin
         cur_phase = phase_ff;
      end else begin
         cur_phase = q_head.first ? PH_ADDR_HIGH : PH_DATA;
      end

      emit.frame_end = 1'b0;
      next_phase     = PH_DATA;
      case (cur_phase)
         PH_ADDR_HIGH: begin
            emit.frame_byte = cfg.addr_high;
            next_phase      = PH_ADDR_LOW;
         end
         PH_ADDR_LOW: begin
            emit.frame_byte = cfg.addr_low;
            next_phase      = PH_CHANNEL;
         end
         PH_CHANNEL: begin
            emit.frame_byte = cfg.channel;
            next_phase      = PH_START;
         end
         PH_START: begin
            emit.frame_byte = rfb_pkg::START_BYTE;
            next_phase      = PH_DATA;
         end
         PH_DATA: begin
            emit.frame_byte = q_head.data;
            next_phase      = PH_SUM;
         end
         PH_SUM: begin
            emit.frame_byte = q_head.sum;
            next_phase      = PH_TERM;
         end
         PH_TERM: begin
            emit.frame_byte = rfb_pkg::TERM_BYTE;
            emit.frame_end  = 1'b1;
            next_phase      = PH_DATA;
         end
         default: begin
            emit.frame_byte = 8'h00;
         end
      endcase

      done  = (cur_phase == PH_DATA && !q_head.last) || cur_phase == PH_TERM;
      q_pop = fire && done;

      busy_in      = busy_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (fire) begin
         busy_in      = !done;
         phase_in     = next_phase;
         out_valid_in = 1'b1;
         out_in       = emit;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_DATA;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   a_busy_has_head: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> q_valid)
      else $error("sequencer busy without queued request");
   a_end_is_term: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_end |-> out_ff.frame_byte == rfb_pkg::TERM_BYTE)
      else $error("frame end on wrong byte");
   a_term_closes: assert property (@(posedge clock) disable iff (reset)
      fire && cur_phase == PH_TERM |=> !busy_ff)
      else $error("sequencer not released after terminator");

endmodule

/* hw/rtl/radio_frame_builder_with_sum_checksum.sv */
// Channel   Direction  Handshake           Payload
// req_      in         req_push / req_full  payload_byte, is_last
// rsp_      out        rsp_empty / rsp_pop  frame_byte, frame_end
// csr_      in         csr_we               index 0..2, 8-bit data
//
// Payload bytes inside a frame go in and out at one per cycle unless rsp_pop
// stalls; the byte sequencer in the back end adds four header bytes before a
// frame's first byte and two trailer bytes after its last. A 4-entry command
// queue sits between front and back. Synchronous reset clears frame state,
// queue and registers. A stalled rsp_pop holds the output register; the queue
// then fills and raises req_full.
module radio_frame_builder_with_sum_checksum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  rfb_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output rfb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [rfb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   rfb_pkg::cfg_type cfg_ff, cfg_in;
   rfb_pkg::cmd_type cmd_data, q_head;
   logic             cmd_push, q_valid, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rfb_pkg::CSR_ADDR_HIGH: cfg_in.addr_high = csr_wdata;
            rfb_pkg::CSR_ADDR_LOW:  cfg_in.addr_low  = csr_wdata;
            rfb_pkg::CSR_CHANNEL:   cfg_in.channel   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_data)
   );

   rfb_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   rfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
